// ===== hdl/rbd_pkg.sv =====
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int SLOT_W     = $clog2(DEPTH);
  localparam int COUNT_W    = $clog2(DEPTH + 1);
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int INDEX_W    = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_BACK   = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_READ       = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RANGE = 2'd3
  } status_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic              shift_back;
    logic              shift_front;
    logic              load;
    logic [SLOT_W-1:0] wr_addr;
    logic [SLOT_W-1:0] rd_addr;
  } cell_ctl_t;

endpackage

// ===== hdl/ring_buffer_deque.sv =====
`timescale 1ns / 1ps
// double-ended queue as a row of 16 shifting cells, front element in cell 0
// results: each accepted operation writes its result into the output register
// throughput: 1 operation per cycle while the output is not stalled, set by the cell shift and read tap
// reset: fill level cleared, output empty; cell contents undefined until pushed
module ring_buffer_deque (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rbd_pkg::KIND_W-1:0]         kind,
  input  logic [rbd_pkg::DATA_WIDTH-1:0]     value,
  input  logic [rbd_pkg::INDEX_W-1:0]        index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rbd_pkg::DATA_WIDTH-1:0]     read_value,
  output logic [rbd_pkg::STATUS_W-1:0]       status,
  output logic [rbd_pkg::COUNT_W-1:0]        count
);

  logic                               accept;
  logic [rbd_pkg::COUNT_W-1:0]        fill;
  logic [rbd_pkg::COUNT_W-1:0]        fill_next;
  rbd_pkg::status_t                   st;
  logic                               rd_en;
  rbd_pkg::cell_ctl_t                 ctl;
  rbd_pkg::cell_ctl_t                 ctl_op;
  logic [rbd_pkg::DATA_WIDTH-1:0]     cell_data [rbd_pkg::DEPTH];
  logic [rbd_pkg::DATA_WIDTH-1:0]     cell_tap  [rbd_pkg::DEPTH];
  logic [rbd_pkg::DATA_WIDTH-1:0]     rd_bus;
  logic                               full;
  logic                               empty;
  logic [rbd_pkg::COUNT_W-1:0]        fill_dec;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (fill == rbd_pkg::COUNT_W'(rbd_pkg::DEPTH));
  assign empty    = (fill == '0);
  assign fill_dec = fill - rbd_pkg::COUNT_W'(1);

  always_comb begin
    ctl_op             = '0;
    st                 = rbd_pkg::STATUS_OK;
    rd_en              = 1'b0;
    fill_next          = fill;
    case (rbd_pkg::kind_t'(kind))
      rbd_pkg::KIND_PUSH_BACK: begin
        if (full) begin
          st = rbd_pkg::STATUS_FULL;
        end else begin
          ctl_op.load    = 1'b1;
          ctl_op.wr_addr = fill[rbd_pkg::SLOT_W-1:0];
          fill_next      = fill + rbd_pkg::COUNT_W'(1);
        end
      end
      rbd_pkg::KIND_PUSH_FRONT: begin
        if (full) begin
          st = rbd_pkg::STATUS_FULL;
        end else begin
          ctl_op.shift_back = 1'b1;
          fill_next         = fill + rbd_pkg::COUNT_W'(1);
        end
      end
      rbd_pkg::KIND_POP_BACK: begin
        if (empty) begin
          st = rbd_pkg::STATUS_EMPTY;
        end else begin
          rd_en          = 1'b1;
          ctl_op.rd_addr = fill_dec[rbd_pkg::SLOT_W-1:0];
          fill_next      = fill_dec;
        end
      end
      rbd_pkg::KIND_POP_FRONT: begin
        if (empty) begin
          st = rbd_pkg::STATUS_EMPTY;
        end else begin
          rd_en              = 1'b1;
          ctl_op.rd_addr     = '0;
          ctl_op.shift_front = 1'b1;
          fill_next          = fill_dec;
        end
      end
      rbd_pkg::KIND_READ: begin
        if (rbd_pkg::COUNT_W'(index) >= fill) begin
          st = rbd_pkg::STATUS_RANGE;
        end else begin
          rd_en          = 1'b1;
          ctl_op.rd_addr = rbd_pkg::SLOT_W'(index);
        end
      end
      default: begin
      end
    endcase
  end

  // cells only move on a transfer; read address stays live for the tap bus
  always_comb begin
    ctl             = ctl_op;
    ctl.shift_back  = ctl_op.shift_back && accept;
    ctl.shift_front = ctl_op.shift_front && accept;
    ctl.load        = ctl_op.load && accept;
  end

  for (genvar i = 0; i < rbd_pkg::DEPTH; i++) begin : g_cell
    logic [rbd_pkg::DATA_WIDTH-1:0] front_in;
    logic [rbd_pkg::DATA_WIDTH-1:0] back_in;
    if (i == 0) begin : g_first
      assign front_in = value;
    end else begin : g_mid
      assign front_in = cell_data[i-1];
    end
    if (i == rbd_pkg::DEPTH - 1) begin : g_last
      assign back_in = '0;
    end else begin : g_inner
      assign back_in = cell_data[i+1];
    end
    rbd_cell u_cell (
      .clk        (clk),
      .idx        (rbd_pkg::SLOT_W'(i)),
      .ctl        (ctl),
      .value      (value),
      .from_front (front_in),
      .from_back  (back_in),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < rbd_pkg::DEPTH; i++) begin
      rd_bus = rd_bus | cell_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= rd_en ? rd_bus : '0;
      status     <= st;
      count      <= fill_next;
    end
  end

endmodule

// ===== hdl/rbd_cell.sv =====
`timescale 1ns / 1ps

module rbd_cell (
  input  logic                            clk,
  input  logic [rbd_pkg::SLOT_W-1:0]      idx,
  input  rbd_pkg::cell_ctl_t              ctl,
  input  logic [rbd_pkg::DATA_WIDTH-1:0]  value,
  input  logic [rbd_pkg::DATA_WIDTH-1:0]  from_front,
  input  logic [rbd_pkg::DATA_WIDTH-1:0]  from_back,
  output logic [rbd_pkg::DATA_WIDTH-1:0]  data,
  output logic [rbd_pkg::DATA_WIDTH-1:0]  tap
);

  always_ff @(posedge clk) begin
    if (ctl.shift_back) begin
      data <= from_front;
    end else if (ctl.shift_front) begin
      data <= from_back;
    end else if (ctl.load && (ctl.wr_addr == idx)) begin
      data <= value;
    end
  end

  assign tap = (ctl.rd_addr == idx) ? data : '0;

endmodule

// ===== sim/deque_checker.sv =====
`timescale 1ns / 1ps

module deque_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [rbd_pkg::KIND_W-1:0]        kind,
  input  logic [rbd_pkg::DATA_WIDTH-1:0]    value,
  input  logic [rbd_pkg::INDEX_W-1:0]       index,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [rbd_pkg::DATA_WIDTH-1:0]    read_value,
  input  logic [rbd_pkg::STATUS_W-1:0]      status,
  input  logic [rbd_pkg::COUNT_W-1:0]       count,
  output int                                fail_count,
  output int                                outstanding
);

  typedef struct {
    logic [rbd_pkg::DATA_WIDTH-1:0] data;
    rbd_pkg::status_t               st;
    logic [rbd_pkg::COUNT_W-1:0]    held_after;
  } deque_result_t;

  logic [rbd_pkg::DATA_WIDTH-1:0] slots [rbd_pkg::DEPTH];
  logic [rbd_pkg::SLOT_W-1:0]     front_slot;
  logic [rbd_pkg::COUNT_W-1:0]    held;
  deque_result_t                  pending_results [$];

  function automatic deque_result_t apply_deque_op(logic [rbd_pkg::KIND_W-1:0] k,
                                                   logic [rbd_pkg::DATA_WIDTH-1:0] v,
                                                   logic [rbd_pkg::INDEX_W-1:0] idx);
    deque_result_t              r;
    logic [rbd_pkg::SLOT_W-1:0] slot;
    r.data = '0;
    r.st   = rbd_pkg::STATUS_OK;
    case (k)
      rbd_pkg::KIND_PUSH_BACK: begin
        if (held == rbd_pkg::COUNT_W'(rbd_pkg::DEPTH)) begin
          r.st = rbd_pkg::STATUS_FULL;
        end else begin
          slot        = front_slot + held[rbd_pkg::SLOT_W-1:0];
          slots[slot] = v;
          held        = held + rbd_pkg::COUNT_W'(1);
        end
      end
      rbd_pkg::KIND_PUSH_FRONT: begin
        if (held == rbd_pkg::COUNT_W'(rbd_pkg::DEPTH)) begin
          r.st = rbd_pkg::STATUS_FULL;
        end else begin
          front_slot        = front_slot - rbd_pkg::SLOT_W'(1);
          slots[front_slot] = v;
          held              = held + rbd_pkg::COUNT_W'(1);
        end
      end
      rbd_pkg::KIND_POP_BACK: begin
        if (held == '0) begin
          r.st = rbd_pkg::STATUS_EMPTY;
        end else begin
          held   = held - rbd_pkg::COUNT_W'(1);
          slot   = front_slot + held[rbd_pkg::SLOT_W-1:0];
          r.data = slots[slot];
        end
      end
      rbd_pkg::KIND_POP_FRONT: begin
        if (held == '0) begin
          r.st = rbd_pkg::STATUS_EMPTY;
        end else begin
          r.data     = slots[front_slot];
          front_slot = front_slot + rbd_pkg::SLOT_W'(1);
          held       = held - rbd_pkg::COUNT_W'(1);
        end
      end
      rbd_pkg::KIND_READ: begin
        if (rbd_pkg::COUNT_W'(idx) >= held) begin
          r.st = rbd_pkg::STATUS_RANGE;
        end else begin
          slot   = front_slot + rbd_pkg::SLOT_W'(idx);
          r.data = slots[slot];
        end
      end
      default: begin
      end
    endcase
    r.held_after = held;
    return r;
  endfunction

  always @(posedge clk) begin
    deque_result_t e;
    int            bad;
    bad = 0;
    if (rst) begin
      front_slot = '0;
      held       = '0;
      pending_results.delete();
      fail_count <= 0;
    end else begin
      // a result leaving now belongs to an earlier accepted operation, so compare before predicting
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result data=%h status=%0d count=%0d",
                   $time, read_value, status, count);
          bad++;
        end else begin
          e = pending_results.pop_front();
          if (read_value !== e.data) begin
            $display("%0t: read_value expected %h actual %h", $time, e.data, read_value);
            bad++;
          end
          if (status !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, status);
            bad++;
          end
          if (count !== e.held_after) begin
            $display("%0t: count expected %0d actual %0d", $time, e.held_after, count);
            bad++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_results.push_back(apply_deque_op(kind, value, index));
      end
      if (bad != 0) begin
        fail_count <= fail_count + bad;
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int NUM_OPS     = 900;
  localparam int QUIET_LIMIT = 5000;

  logic                           clk        = 1'b0;
  logic                           rst        = 1'b1;
  logic                           in_valid   = 1'b0;
  logic                           in_stall;
  logic [rbd_pkg::KIND_W-1:0]     kind       = '0;
  logic [rbd_pkg::DATA_WIDTH-1:0] value      = '0;
  logic [rbd_pkg::INDEX_W-1:0]    index      = '0;
  logic                           out_valid;
  logic                           out_stall  = 1'b0;
  logic [rbd_pkg::DATA_WIDTH-1:0] read_value;
  logic [rbd_pkg::STATUS_W-1:0]   status;
  logic [rbd_pkg::COUNT_W-1:0]    count;
  int                             fail_count;
  int                             outstanding;
  int                             quiet_cycles = 0;
  int                             stall_left   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ring_buffer_deque i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .value      (value),
    .index      (index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .status     (status),
    .count      (count)
  );

  deque_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .value       (value),
    .index       (index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .status      (status),
    .count       (count),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // receiver back-pressure: runs of free flow, short stalls and the odd long one
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (r < 50) begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 20);
    end else if (r < 90) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(4, 40);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_op(input logic [rbd_pkg::KIND_W-1:0] k,
                         input logic [rbd_pkg::DATA_WIDTH-1:0] v,
                         input logic [rbd_pkg::INDEX_W-1:0] idx);
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    index    <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int gap_length(input bit busy);
    int r;
    r = $urandom_range(0, 99);
    if (busy || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [rbd_pkg::DATA_WIDTH-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  // burst flavours: 0 filling, 1 draining, 2 balanced with reads, 3 any code
  function automatic logic [rbd_pkg::KIND_W-1:0] pick_kind(input int flavour);
    int r;
    r = $urandom_range(0, 99);
    case (flavour)
      0: begin
        if (r < 80) begin
          return $urandom_range(0, 1) ? rbd_pkg::KIND_PUSH_FRONT : rbd_pkg::KIND_PUSH_BACK;
        end
        if (r < 90) return rbd_pkg::KIND_READ;
        return $urandom_range(0, 1) ? rbd_pkg::KIND_POP_FRONT : rbd_pkg::KIND_POP_BACK;
      end
      1: begin
        if (r < 80) begin
          return $urandom_range(0, 1) ? rbd_pkg::KIND_POP_FRONT : rbd_pkg::KIND_POP_BACK;
        end
        if (r < 90) return rbd_pkg::KIND_READ;
        return $urandom_range(0, 1) ? rbd_pkg::KIND_PUSH_FRONT : rbd_pkg::KIND_PUSH_BACK;
      end
      2: begin
        if (r < 30) begin
          return $urandom_range(0, 1) ? rbd_pkg::KIND_PUSH_FRONT : rbd_pkg::KIND_PUSH_BACK;
        end
        if (r < 60) begin
          return $urandom_range(0, 1) ? rbd_pkg::KIND_POP_FRONT : rbd_pkg::KIND_POP_BACK;
        end
        return rbd_pkg::KIND_READ;
      end
      default: return rbd_pkg::KIND_W'($urandom_range(0, 7));
    endcase
  endfunction

  // codes outside the defined operations
  function automatic logic [rbd_pkg::KIND_W-1:0] KW5();
    return rbd_pkg::KIND_W'(5);
  endfunction

  function automatic logic [rbd_pkg::KIND_W-1:0] KW6();
    return rbd_pkg::KIND_W'(6);
  endfunction

  function automatic logic [rbd_pkg::KIND_W-1:0] KW7();
    return rbd_pkg::KIND_W'(7);
  endfunction

  initial begin
    int                         sent;
    int                         burst_len;
    int                         flavour;
    int                         r;
    bit                         busy;
    logic [rbd_pkg::KIND_W-1:0] k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty queue, unused codes, extremes of data, reads at and past the count
    send_op(rbd_pkg::KIND_POP_BACK, '1, '1);          idle_gap(gap_length(0));
    send_op(rbd_pkg::KIND_POP_FRONT, '1, '0);         idle_gap(gap_length(0));
    send_op(rbd_pkg::KIND_READ, '0, '0);              idle_gap(gap_length(0));
    send_op(KW5(), '1, '1);                           idle_gap(gap_length(0));
    send_op(KW6(), '0, '0);                           idle_gap(gap_length(0));
    send_op(KW7(), 32'hdead_beef, 4'h5);              idle_gap(gap_length(0));
    send_op(rbd_pkg::KIND_PUSH_BACK, '1, '0);         idle_gap(gap_length(0));
    send_op(rbd_pkg::KIND_PUSH_FRONT, '0, '1);        idle_gap(gap_length(0));
    send_op(rbd_pkg::KIND_PUSH_BACK, 32'ha5a5_a5a5, '0);
    send_op(rbd_pkg::KIND_PUSH_FRONT, 32'h5a5a_5a5a, '0);
    send_op(rbd_pkg::KIND_READ, '0, 4'd0);
    send_op(rbd_pkg::KIND_READ, '0, 4'd3);
    send_op(rbd_pkg::KIND_READ, '0, 4'd4);
    send_op(rbd_pkg::KIND_READ, '0, 4'd15);
    send_op(KW7(), '1, '1);
    send_op(rbd_pkg::KIND_POP_BACK, '0, '0);          idle_gap(gap_length(0));
    send_op(rbd_pkg::KIND_POP_FRONT, '0, '0);
    send_op(rbd_pkg::KIND_POP_FRONT, '0, '0);
    send_op(rbd_pkg::KIND_POP_BACK, '0, '0);
    send_op(rbd_pkg::KIND_POP_BACK, '0, '0);          idle_gap(gap_length(0));

    sent = 0;
    while (sent < NUM_OPS) begin
      burst_len = $urandom_range(10, 60);
      r         = $urandom_range(0, 99);
      flavour   = (r < 30) ? 0 : (r < 60) ? 1 : (r < 90) ? 2 : 3;
      busy      = ($urandom_range(0, 99) < 30);
      repeat (burst_len) begin
        k = pick_kind(flavour);
        send_op(k, pick_value(), rbd_pkg::INDEX_W'($urandom_range(0, 15)));
        if (k <= rbd_pkg::KIND_READ) sent++;
        idle_gap(gap_length(busy));
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rbd_pkg.sv
hdl/rbd_cell.sv
hdl/ring_buffer_deque.sv
sim/deque_checker.sv
sim/tb.sv
